/* rtl/tmcw_pkg.sv */
// Shared types and constants for the text-mode console writer.
// Holds the word layouts, opcodes, sequencer states and register map.
// No dependencies.
package tmcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Field widths
  localparam int CELL_W = 16;
  localparam int LOC_W  = 11;
  localparam int POS_W  = 16;

  // Config port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Cell and attribute constants
  localparam logic [CELL_W-1:0] BLANK_CELL         = 16'h0F00;
  localparam logic [7:0]        ERROR_ATTR         = 8'h04;
  localparam logic [7:0]        SPACE_CHAR         = 8'h20;
  localparam logic [7:0]        DEFAULT_ATTR_RESET = 8'h0F;
  localparam logic              CURSOR_EN_RESET    = 1'b1;

  // Command opcodes
  typedef enum logic [2:0] {
    OP_CHAR       = 3'd0,
    OP_CR         = 3'd1,
    OP_LF         = 3'd2,
    OP_BS         = 3'd3,
    OP_SET_CURSOR = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_READ_CELL  = 3'd6,
    OP_NOP        = 3'd7
  } op_t;

  // Register index (word address)
  typedef enum logic {
    REG_DEFAULT_ATTR = 1'b0,
    REG_CURSOR_EN    = 1'b1
  } reg_idx_t;

  // Command word
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] cell_attr;
    logic       use_active;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

  // Response word
  typedef struct packed {
    logic [LOC_W-1:0]  cursor_location;
    logic              cursor_written;
    logic [CELL_W-1:0] cell_value;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCROLL,
    ST_WRITE,
    ST_RESTORE,
    ST_READ,
    ST_FINISH
  } seq_state_t;

  // Buffer sweep modes
  typedef enum logic [1:0] {
    SW_IDLE,
    SW_CLEAR,
    SW_SCROLL
  } sweep_t;

  // Requests from the sequencer to the cell store
  typedef struct packed {
    logic clear_start;
    logic scroll_start;
    logic wr_en;
    logic rd_en;
  } store_req_t;

  // Position check result
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
    logic       err;
    logic       scroll;
  } chk_t;

endpackage

/* rtl/tmcw_stream_if.sv */
// Valid/ready stream channel used for the command and response words.
// The word type is a parameter; no other dependencies.
interface tmcw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/tmcw_pos_unit.sv */
// Shared position unit: cursor range check, wrap and scroll detect, and
// the linear cell index col + row * COLUMNS. Uses tmcw_pkg.
module tmcw_pos_unit #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
  input  logic [7:0]                 col,
  input  logic [7:0]                 row,
  output tmcw_pkg::chk_t             chk,
  output logic [tmcw_pkg::POS_W-1:0] pos
);
  import tmcw_pkg::*;

  localparam logic [7:0] COLS8 = 8'(COLUMNS);
  localparam logic [7:0] ROWS8 = 8'(ROWS);

  logic       err;
  logic       wrap;
  logic [7:0] c1, r1, c2, r2;

  // Out of range: back to origin with the error attribute
  assign err = (col > COLS8) || (row > ROWS8);
  assign c1  = err ? 8'd0 : col;
  assign r1  = err ? 8'd0 : row;

  // Column at the right edge wraps to the next row
  assign wrap = (c1 == COLS8);
  assign c2   = wrap ? 8'd0 : c1;
  assign r2   = (wrap && (r1 != ROWS8)) ? r1 + 8'd1 : r1;

  // Row past the bottom scrolls and lands on the last row
  always_comb begin
    chk.err    = err;
    chk.col    = c2;
    chk.scroll = (r2 == ROWS8);
    chk.row    = (r2 == ROWS8) ? 8'(ROWS - 1) : r2;
  end

  // Linear index
  assign pos = POS_W'(col) + POS_W'(row) * POS_W'(COLUMNS);

endmodule

/* rtl/tmcw_cell_store.sv */
// Screen cell memory with its sweep engine (clear and scroll-up walks).
// One write and one registered read per cycle. Uses tmcw_pkg.
module tmcw_cell_store #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int ADDR_W = $clog2(CELLS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tmcw_pkg::store_req_t        req,
  input  logic [ADDR_W-1:0]           addr,
  input  logic [tmcw_pkg::CELL_W-1:0] wdata,
  output logic [tmcw_pkg::CELL_W-1:0] rdata,
  output logic                        sweep_done
);
  import tmcw_pkg::*;

  localparam int CNT_W   = $clog2(CELLS + 1);
  localparam int SHIFT_N = CELLS - COLUMNS;

  logic [CELL_W-1:0] mem [CELLS];

  sweep_t            mode;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cnt_fwd;
  logic              we;
  logic              re;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] wd;

  assign cnt_dec = cnt - 1'b1;
  assign cnt_fwd = cnt + CNT_W'(COLUMNS);

  // Clear walks every cell once; scroll reads one row ahead and writes
  // one cell behind, then blanks the last row
  assign sweep_done = ((mode == SW_CLEAR) && (cnt == CNT_W'(CELLS - 1))) ||
                      ((mode == SW_SCROLL) && (cnt == CNT_W'(CELLS)));

  // Sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= SW_CLEAR;
      cnt  <= '0;
    end else begin
      case (mode)
        SW_IDLE: begin
          cnt <= '0;
          if (req.clear_start) begin
            mode <= SW_CLEAR;
          end else if (req.scroll_start) begin
            mode <= SW_SCROLL;
          end
        end
        SW_CLEAR, SW_SCROLL: begin
          if (sweep_done) begin
            mode <= SW_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: mode <= SW_IDLE;
      endcase
    end
  end

  // Port steering
  always_comb begin
    case (mode)
      SW_CLEAR: begin
        we    = 1'b1;
        waddr = cnt[ADDR_W-1:0];
        wd    = BLANK_CELL;
        re    = 1'b0;
        raddr = addr;
      end
      SW_SCROLL: begin
        we    = (cnt != '0);
        waddr = cnt_dec[ADDR_W-1:0];
        wd    = (cnt_dec < CNT_W'(SHIFT_N)) ? rdata : BLANK_CELL;
        re    = (cnt < CNT_W'(SHIFT_N));
        raddr = cnt_fwd[ADDR_W-1:0];
      end
      default: begin
        we    = req.wr_en;
        waddr = addr;
        wd    = wdata;
        re    = req.rd_en;
        raddr = addr;
      end
    endcase
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wd;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

`ifndef SYNTH
  // A finished sweep returns the store to idle
  property p_done_to_idle;
    @(posedge clk) disable iff (rst) sweep_done |=> (mode == SW_IDLE);
  endproperty
  a_done_to_idle: assert property (p_done_to_idle)
    else $error("cell store: sweep did not end after done");

  // No outside access while a sweep owns the ports
  property p_no_access_in_sweep;
    @(posedge clk) disable iff (rst)
      (mode != SW_IDLE) |-> (!req.wr_en && !req.rd_en);
  endproperty
  a_no_access_in_sweep: assert property (p_no_access_in_sweep)
    else $error("cell store: access request during sweep");

  // Scroll writes always trail the reads
  property p_scroll_order;
    @(posedge clk) disable iff (rst)
      ((mode == SW_SCROLL) && we && re) |-> (waddr < raddr);
  endproperty
  a_scroll_order: assert property (p_scroll_order)
    else $error("cell store: scroll write overtook read");
`endif

endmodule

/* rtl/text_mode_console_writer_unit.sv */
// Text-mode console writer top level (needs tmcw_pkg, tmcw_stream_if,
// tmcw_pos_unit, tmcw_cell_store): a COLUMNS x ROWS buffer of 16-bit cells
// with a cursor and an active attribute, driven by command words on cmd and
// answering each with one response word on rsp. One command is in work at a
// time, stepped by a small sequencer around one shared position unit and
// the single-write cell memory. Steps per command, accept to response: read
// cell reads when in range, then finishes; cursor moves (CR, LF, set cursor)
// check and finish; a character write checks, writes and, with the cursor
// update on, checks again; backspace also restores the cursor and checks once
// more; a check that scrolls adds a memory walk, and clear screen walks all
// cells. After reset a clearing pass over all cells runs before the first
// command is taken; config writes are taken at all times. A finished response
// waits in the output register without blocking the next command.
module text_mode_console_writer_unit #(
  parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  tmcw_stream_if.sink                     cmd,
  tmcw_stream_if.source                   rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmcw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tmcw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tmcw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tmcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  seq_state_t        state, state_next;
  seq_state_t        cont, cont_next;
  op_t               op;
  reg_idx_t          reg_idx;
  store_req_t        store_req;
  chk_t              chk;
  logic [POS_W-1:0]  pos;
  logic [7:0]        pos_col, pos_row;
  logic [CELL_W-1:0] store_rdata;
  logic              sweep_done;

  logic [7:0] cur_col, cur_row;
  logic [7:0] back_col, back_row;
  logic [7:0] bs_col, bs_row;
  logic [7:0] req_col, req_row;
  logic [7:0] wchar, wattr;
  logic [7:0] active_attr, base_attr;
  logic       cursor_en;
  logic       is_bs, written, rd_ok;
  logic       accept, rd_in_range, rsp_free, cfg_wr;

  assign op          = op_t'(cmd.payload.opcode);
  assign cmd.ready   = (state == ST_IDLE);
  assign accept      = cmd.valid && cmd.ready;
  assign rsp_free    = !rsp.valid || rsp.ready;
  assign rd_in_range = (cmd.payload.col < 8'(COLUMNS)) && (cmd.payload.row < 8'(ROWS));

  // Backspace target: one column left, or last column of the row above
  assign back_col = (cur_col != 8'd0) ? cur_col - 8'd1 : 8'(COLUMNS - 1);
  assign back_row = (cur_col != 8'd0) ? cur_row : cur_row - 8'd1;

  // Config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1]);

  always_comb begin
    case (reg_idx)
      REG_DEFAULT_ATTR: prdata = APB_DATA_W'(base_attr);
      REG_CURSOR_EN:    prdata = APB_DATA_W'(cursor_en);
      default:          prdata = '0;
    endcase
  end

  // Shared position unit
  assign pos_col = (state == ST_READ) ? req_col : cur_col;
  assign pos_row = (state == ST_READ) ? req_row : cur_row;

  tmcw_pos_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_pos (
    .col (pos_col),
    .row (pos_row),
    .chk (chk),
    .pos (pos)
  );

  // Cell memory and sweep engine
  tmcw_cell_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .req        (store_req),
    .addr       (pos[ADDR_W-1:0]),
    .wdata      ({wattr, wchar}),
    .rdata      (store_rdata),
    .sweep_done (sweep_done)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cont  <= ST_IDLE;
    end else begin
      state <= state_next;
      cont  <= cont_next;
    end
  end

  // Sequencer next state and store requests
  always_comb begin
    state_next = state;
    cont_next  = cont;
    store_req  = '0;
    case (state)
      ST_CLEAR, ST_SCROLL: begin
        if (sweep_done) begin
          state_next = cont;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_CHAR, OP_BS: begin
              state_next = ST_CHECK;
              cont_next  = ST_WRITE;
            end
            OP_CR, OP_LF, OP_SET_CURSOR: begin
              state_next = ST_CHECK;
              cont_next  = ST_FINISH;
            end
            OP_CLEAR: begin
              store_req.clear_start = 1'b1;
              state_next            = ST_CLEAR;
              cont_next             = ST_FINISH;
            end
            OP_READ_CELL: state_next = rd_in_range ? ST_READ : ST_FINISH;
            default:      state_next = ST_FINISH;
          endcase
        end
      end
      ST_CHECK: begin
        if (chk.scroll) begin
          store_req.scroll_start = 1'b1;
          state_next             = ST_SCROLL;
        end else begin
          state_next = cont;
        end
      end
      ST_WRITE: begin
        store_req.wr_en = 1'b1;
        if (cursor_en) begin
          state_next = ST_CHECK;
          cont_next  = is_bs ? ST_RESTORE : ST_FINISH;
        end else begin
          state_next = is_bs ? ST_RESTORE : ST_FINISH;
        end
      end
      ST_RESTORE: begin
        state_next = ST_CHECK;
        cont_next  = ST_FINISH;
      end
      ST_READ: begin
        store_req.rd_en = 1'b1;
        state_next      = ST_FINISH;
      end
      ST_FINISH: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Cursor, attributes, registers and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      active_attr <= DEFAULT_ATTR_RESET;
      base_attr   <= DEFAULT_ATTR_RESET;
      cursor_en   <= CURSOR_EN_RESET;
      rsp.valid   <= 1'b0;
    end else begin
      // register writes
      if (cfg_wr) begin
        case (reg_idx)
          REG_DEFAULT_ATTR: begin
            base_attr   <= pwdata[7:0];
            active_attr <= pwdata[7:0];
          end
          REG_CURSOR_EN: cursor_en <= pwdata[0];
          default: ;
        endcase
      end

      // cursor updates
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              OP_CR: cur_col <= '0;
              OP_LF: cur_row <= cur_row + 8'd1;
              OP_BS: begin
                cur_col <= back_col;
                cur_row <= back_row;
              end
              OP_SET_CURSOR: begin
                cur_col <= cmd.payload.col;
                cur_row <= cmd.payload.row;
              end
              OP_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_CHECK: begin
          cur_col <= chk.col;
          cur_row <= chk.row;
          if (chk.err) begin
            active_attr <= ERROR_ATTR;
          end
        end
        ST_WRITE: cur_col <= cur_col + 8'd1;
        ST_RESTORE: begin
          cur_col <= bs_col;
          cur_row <= bs_row;
        end
        default: ;
      endcase

      // response valid
      if ((state == ST_FINISH) && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Per-command latches and response word
  always_ff @(posedge clk) begin
    if (accept) begin
      wchar   <= (op == OP_BS) ? SPACE_CHAR : cmd.payload.char_code;
      wattr   <= ((op == OP_BS) || cmd.payload.use_active) ? active_attr
                                                           : cmd.payload.cell_attr;
      is_bs   <= (op == OP_BS);
      bs_col  <= back_col;
      bs_row  <= back_row;
      req_col <= cmd.payload.col;
      req_row <= cmd.payload.row;
      rd_ok   <= (op == OP_READ_CELL) && rd_in_range;
      written <= (op == OP_CHAR) ? cursor_en
                                 : ((op != OP_READ_CELL) && (op != OP_NOP));
    end
    if ((state == ST_FINISH) && rsp_free) begin
      rsp.payload.cursor_location <= written ? pos[LOC_W-1:0] : '0;
      rsp.payload.cursor_written  <= written;
      rsp.payload.cell_value      <= rd_ok ? store_rdata : '0;
    end
  end

`ifndef SYNTH
  // Every position check leaves the cursor on the screen
  property p_check_in_range;
    @(posedge clk) disable iff (rst)
      (state == ST_CHECK) |=> ((cur_col < 8'(COLUMNS)) && (cur_row < 8'(ROWS)));
  endproperty
  a_check_in_range: assert property (p_check_in_range)
    else $error("console: cursor off screen after check");

  // A sweep request always parks the sequencer until the walk is over
  property p_sweep_wait;
    @(posedge clk) disable iff (rst)
      (store_req.clear_start || store_req.scroll_start) |=>
        ((state == ST_CLEAR) || (state == ST_SCROLL));
  endproperty
  a_sweep_wait: assert property (p_sweep_wait)
    else $error("console: sweep started without waiting");

  // Character writes land inside the buffer
  property p_write_in_buffer;
    @(posedge clk) disable iff (rst)
      (state == ST_WRITE) |-> (pos < POS_W'(CELLS));
  endproperty
  a_write_in_buffer: assert property (p_write_in_buffer)
    else $error("console: cell write outside buffer");
`endif

endmodule

/* sim/text_mode_console_writer_unit_tb.sv */
// Testbench for text_mode_console_writer_unit: drives command words and APB
// register writes, predicts every response word and compares them in order.
// Depends on rtl/tmcw_pkg.sv, rtl/tmcw_stream_if.sv and the RTL of the block.
`timescale 1ns / 100ps

module text_mode_console_writer_unit_tb;
  import tmcw_pkg::*;

  localparam int COLS        = COLUMNS_DEFAULT;
  localparam int ROWS_N      = ROWS_DEFAULT;
  localparam int CELLS       = COLS * ROWS_N;
  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYC   = 7;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES    = 6;
  localparam int PHASE_ITEMS = 150;

  // Console model: screen, cursor, attributes and the queue of expected words
  class console_scoreboard;
    logic [15:0] cells [CELLS];
    logic [7:0]  cur_col, cur_row, act_attr, def_attr;
    logic        cur_en;
    rsp_t        expected_rsp_q [$];
    int          errors, checked, scrolls, pos_resets, reads, clears;

    function new();
      for (int r = 0; r < ROWS_N; r++) blank_row(r);
      cur_col  = '0;
      cur_row  = '0;
      def_attr = DEFAULT_ATTR_RESET;
      act_attr = DEFAULT_ATTR_RESET;
      cur_en   = CURSOR_EN_RESET;
    endfunction

    function void blank_row(int r);
      for (int i = 0; i < COLS; i++) cells[r * COLS + i] = BLANK_CELL;
    endfunction

    // Range check, column wrap and scroll, in that order
    function void check_position();
      if (cur_col > COLS || cur_row > ROWS_N) begin
        act_attr = ERROR_ATTR;
        cur_col  = '0;
        cur_row  = '0;
        pos_resets++;
      end
      if (cur_col == COLS) begin
        cur_col = '0;
        if (cur_row != ROWS_N) cur_row = cur_row + 8'd1;
      end
      if (cur_row == ROWS_N) begin
        for (int i = 0; i < COLS * (ROWS_N - 1); i++) cells[i] = cells[i + COLS];
        blank_row(ROWS_N - 1);
        cur_row = 8'(ROWS_N - 1);
        scrolls++;
      end
    endfunction

    function logic [10:0] move_cursor(int c, int r);
      cur_col = c[7:0];
      cur_row = r[7:0];
      check_position();
      return 11'(int'(cur_col) + int'(cur_row) * COLS);
    endfunction

    function bit write_char(logic [7:0] ch, logic [7:0] attr, output logic [10:0] loc);
      int pos;
      check_position();
      pos = int'(cur_col) + int'(cur_row) * COLS;
      if (pos < CELLS) cells[pos] = {attr, ch};
      cur_col = cur_col + 8'd1;
      loc = '0;
      if (cur_en) begin
        loc = move_cursor(cur_col, cur_row);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function rsp_t predict_rsp(cmd_t c);
      rsp_t        e;
      logic [10:0] loc;
      logic [10:0] unused_loc;
      logic [15:0] rd_cell;
      logic [7:0]  bc, br;
      bit          wr;
      loc     = '0;
      rd_cell = '0;
      wr      = 1'b0;
      case (op_t'(c.opcode))
        OP_CHAR: begin
          wr = write_char(c.char_code, c.use_active ? act_attr : c.cell_attr, loc);
        end
        OP_CR: begin
          loc = move_cursor(0, cur_row);
          wr  = 1'b1;
        end
        OP_LF: begin
          loc = move_cursor(cur_col, int'(cur_row) + 1);
          wr  = 1'b1;
        end
        OP_BS: begin
          // step back, row wraps modulo 256 from column 0
          if (cur_col != 0) begin
            cur_col = cur_col - 8'd1;
          end else begin
            cur_col = 8'(COLS - 1);
            cur_row = cur_row - 8'd1;
          end
          bc = cur_col;
          br = cur_row;
          void'(write_char(SPACE_CHAR, act_attr, unused_loc));
          loc = move_cursor(bc, br);
          wr  = 1'b1;
        end
        OP_SET_CURSOR: begin
          loc = move_cursor(c.col, c.row);
          wr  = 1'b1;
        end
        OP_CLEAR: begin
          for (int r = 0; r < ROWS_N; r++) blank_row(r);
          loc = move_cursor(0, 0);
          wr  = 1'b1;
          clears++;
        end
        OP_READ_CELL: begin
          if (c.col < COLS && c.row < ROWS_N)
            rd_cell = cells[int'(c.col) + int'(c.row) * COLS];
          reads++;
        end
        default: ;
      endcase
      if (!wr) loc = '0;
      e.cursor_location = loc;
      e.cursor_written  = wr;
      e.cell_value      = rd_cell;
      return e;
    endfunction

    function void note_cmd(cmd_t c);
      expected_rsp_q.push_back(predict_rsp(c));
    endfunction

    function void note_config(reg_idx_t idx, logic [31:0] data);
      if (idx == REG_DEFAULT_ATTR) begin
        def_attr = data[7:0];
        act_attr = data[7:0];
      end else begin
        cur_en = data[0];
      end
    endfunction

    function int pending();
      return expected_rsp_q.size();
    endfunction

    task report(string what);
      $display("ERROR @%0t: %s", $time, what);
      errors++;
    endtask

    task check_rsp(rsp_t got);
      rsp_t exp;
      if (expected_rsp_q.size() == 0) begin
        report($sformatf("response word with nothing expected: %h", got));
        return;
      end
      exp = expected_rsp_q.pop_front();
      checked++;
      if (got.cursor_location !== exp.cursor_location)
        report($sformatf("word %0d cursor_location %0d, expected %0d",
                         checked, got.cursor_location, exp.cursor_location));
      if (got.cursor_written !== exp.cursor_written)
        report($sformatf("word %0d cursor_written %0b, expected %0b",
                         checked, got.cursor_written, exp.cursor_written));
      if (got.cell_value !== exp.cell_value)
        report($sformatf("word %0d cell_value %h, expected %h",
                         checked, got.cell_value, exp.cell_value));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  tmcw_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  tmcw_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  console_scoreboard sb;
  bit calm;       // no idling on either side
  bit hold_req;   // asks the receiver for one long hold-off
  int n_sent;
  int quiet;

  text_mode_console_writer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: checks accepted response words, random stalls, one long hold-off
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) sb.check_rsp(rsp_ch.payload);
      if (hold_cnt != 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  function automatic cmd_t mk(op_t op, int ch, int attr, int ud, int col, int row);
    cmd_t c;
    c.opcode     = op;
    c.char_code  = 8'(ch);
    c.cell_attr  = 8'(attr);
    c.use_active = 1'(ud);
    c.col        = 8'(col);
    c.row        = 8'(row);
    return c;
  endfunction

  // Coordinates around the screen border
  function automatic logic [7:0] edge_coord(int lim);
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'(lim - 1);
      2: return 8'(lim);
      3: return 8'(lim + 1);
      default: return 8'hFF;
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   where;
    c.char_code  = 8'($urandom_range(255));
    c.cell_attr  = 8'($urandom_range(255));
    c.use_active = 1'($urandom_range(1));
    c.col        = 8'($urandom_range(255));
    c.row        = 8'($urandom_range(255));
    pick  = $urandom_range(99);
    where = $urandom_range(99);
    if (pick < 40) begin
      c.opcode = OP_CHAR;
    end else if (pick < 48) begin
      c.opcode = OP_CR;
    end else if (pick < 56) begin
      c.opcode = OP_LF;
    end else if (pick < 66) begin
      c.opcode = OP_BS;
    end else if (pick < 80) begin
      c.opcode = OP_SET_CURSOR;
      if (where < 70) begin
        c.col = 8'($urandom_range(COLS - 1));
        c.row = 8'($urandom_range(ROWS_N - 1));
      end else if (where < 85) begin
        c.col = edge_coord(COLS);
        c.row = edge_coord(ROWS_N);
      end
    end else if (pick < 82) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 97) begin
      c.opcode = OP_READ_CELL;
      if (where < 85) begin
        c.col = 8'($urandom_range(COLS - 1));
        c.row = 8'($urandom_range(ROWS_N - 1));
      end
    end else begin
      c.opcode = OP_NOP;
    end
    return c;
  endfunction

  // Offer one command word, with random gaps before it
  task automatic send_cmd(input cmd_t c);
    while (!calm && $urandom_range(99) < 12) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_cmd(c);
    n_sent++;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle
  task automatic apb_write(input reg_idx_t idx, input logic [7:0] value);
    logic [31:0] data;
    data = $urandom();
    if (idx == REG_DEFAULT_ATTR) data[7:0] = value;
    else data[0] = value[0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.note_config(idx, data);
    @(posedge clk);
  endtask

  // Main sequence
  initial begin
    logic [7:0] attr;
    logic       en;
    sb       = new();
    calm     = 1'b0;
    hold_req = 1'b0;
    n_sent   = 0;
    rst            <= 1'b1;
    cmd_ch.valid   <= 1'b0;
    cmd_ch.payload <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (RESET_CYC) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings, cursor update on
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_CHAR, 8'h41, 0, 1, 0, 0));
    send_cmd(mk(OP_CHAR, 8'hFF, 8'hFF, 0, 0, 0));
    send_cmd(mk(OP_CHAR, 8'h00, 8'h00, 0, 0, 0));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, 2, 0));
    send_cmd(mk(OP_CR, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_LF, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_BS, 0, 0, 0, 0, 0));               // column 0 goes to previous row
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_BS, 0, 0, 0, 0, 0));               // at origin: error attribute
    send_cmd(mk(OP_CHAR, 8'h5A, 0, 1, 0, 0));
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, COLS - 1, ROWS_N - 1));
    send_cmd(mk(OP_CHAR, 8'h7E, 8'h1E, 0, 0, 0));     // wrap on last row scrolls
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, COLS, 3));    // column at width wraps
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, 0, ROWS_N));  // row at height scrolls
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, COLS + 1, 0));
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, 255, 255));
    send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, 10, ROWS_N - 1));
    send_cmd(mk(OP_LF, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, 255, 255));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, COLS, 0));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, 0, ROWS_N));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, COLS - 1, ROWS_N - 1));
    send_cmd(mk(OP_CLEAR, 0, 0, 0, 0, 0));
    send_cmd(mk(OP_READ_CELL, 0, 0, 0, 5, 5));
    send_cmd(mk(OP_NOP, 8'hA5, 8'h5A, 1, 8'hC3, 8'h3C));

    // random phases, one register setting each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin attr = 8'hFF; en = 1'b1; end
        1: begin attr = 8'h00; en = 1'b0; end
        4: begin attr = 8'h80; en = 1'b1; end
        default: begin attr = 8'($urandom_range(255)); en = (ph != 3); end
      endcase
      apb_write(REG_DEFAULT_ATTR, attr);
      apb_write(REG_CURSOR_EN, {7'd0, en});
      calm = (ph == 2);

      // cursor update off: column may rest at the width until the next word
      if (ph == 1) begin
        send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, COLS - 2, 3));
        send_cmd(mk(OP_CHAR, 8'h31, 0, 1, 0, 0));
        send_cmd(mk(OP_CHAR, 8'h32, 8'h2F, 0, 0, 0));
        send_cmd(mk(OP_BS, 0, 0, 0, 0, 0));
        send_cmd(mk(OP_CHAR, 8'h33, 0, 1, 0, 0));
        send_cmd(mk(OP_CHAR, 8'h34, 0, 1, 0, 0));
        send_cmd(mk(OP_READ_CELL, 0, 0, 0, 0, 4));
        send_cmd(mk(OP_SET_CURSOR, 0, 0, 0, COLS - 1, ROWS_N - 1));
        send_cmd(mk(OP_CHAR, 8'h35, 0, 1, 0, 0));
        send_cmd(mk(OP_CHAR, 8'h36, 0, 1, 0, 0));
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 30) hold_req = 1'b1;
        if (ph == 3 && i == 75) wait_drained();
        send_cmd(random_cmd());
      end
      calm = 1'b0;
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Covered %0d command words over %0d register settings, %0d responses checked.",
             n_sent, N_PHASES + 1, sb.checked);
    $display("Model saw %0d scrolls, %0d clears, %0d position resets, %0d cell reads.",
             sb.scrolls, sb.clears, sb.pos_resets, sb.reads);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tmcw_pkg.sv
rtl/tmcw_stream_if.sv
rtl/tmcw_pos_unit.sv
rtl/tmcw_cell_store.sv
rtl/text_mode_console_writer_unit.sv
sim/text_mode_console_writer_unit_tb.sv
